>>> src/assert_macros.svh
// Assertion macros for the RTL; included by frame_bitmap_allocator.sv.
// Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/fba_pkg.sv
`timescale 1ns / 1ps
package fba_pkg;

    localparam int FRAME_COUNT = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);

    // full-word flags are scanned one group of words per cycle
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_SEL_W = $clog2(GROUP_SIZE);
    localparam int GROUP_COUNT = WORD_COUNT / GROUP_SIZE;
    localparam int GROUP_IDX_W = $clog2(GROUP_COUNT);

    localparam int OP_W       = 2;
    localparam int FRAME_W    = 12;
    localparam int ENTRY_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int PAGE_SHIFT = 12;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_NOFREE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_RESP
    } state_t;

    typedef struct packed {
        logic item_load;
        logic grp_inc;
        logic idx_from_scan;
        logic mem_write;
        logic set_present;
        logic set_nofree;
        logic out_load;
    } fba_cmd_t;

    typedef struct packed {
        op_t  op;
        logic present;
        logic grp_hit;
        logic grp_last;
        logic out_free;
    } fba_stat_t;

endpackage

>>> src/frame_bitmap_allocator.sv
// Sequence: free and mark pass decode, read, modify and response; an unused op goes
//   from decode to response, as does allocate for a present entry; other allocates
//   scan full-word flags, 8 words per cycle, then read and modify or report no free frame.
// Throughput: one item at a time; the next item is accepted once the result is
//   registered, even while that result still waits on the output.
// Reset: asynchronous, active low; frames read free at once through per-word valid flags.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frame_bitmap_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op[1:0]
    input  logic [fba_pkg::OP_W-1:0]       s_tuser,
    // frame_number[11:0], existing_entry[43:12], user_flag[44], writable_flag[45], zero[47:46]
    input  logic [fba_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0]
    output logic [fba_pkg::STATUS_W-1:0]   m_tuser,
    // granted_frame[11:0], page_entry[43:12], zero[47:44]
    output logic [fba_pkg::OUT_DATA_W-1:0] m_tdata
);

    fba_pkg::fba_cmd_t  cmd;
    fba_pkg::fba_stat_t stat;

    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fba_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    `ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLIES(a_out_slot_free, clk, rst_n, cmd.out_load, !m_tvalid || m_tready)
    `ASSERT_IMPLIES(a_no_write_on_accept, clk, rst_n, cmd.mem_write, !s_tready)
    `ASSERT_NEXT(a_result_follows_write, clk, rst_n, cmd.mem_write, !s_tready)

endmodule

>>> src/fba_ram.sv
`timescale 1ns / 1ps
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fba_ctrl.sv
`timescale 1ns / 1ps
module fba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fba_pkg::fba_stat_t stat,
    output fba_pkg::fba_cmd_t  cmd
);

    fba_pkg::state_t state_reg;
    fba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            fba_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = fba_pkg::S_DECODE;
                end
            end
            fba_pkg::S_DECODE:
            begin
                unique case (stat.op)
                    fba_pkg::OP_ALLOC:
                    begin
                        if (stat.present)
                        begin
                            cmd.set_present = 1'b1;
                            state_next      = fba_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = fba_pkg::S_SCAN;
                        end
                    end
                    fba_pkg::OP_FREE,
                    fba_pkg::OP_MARK:
                    begin
                        state_next = fba_pkg::S_READ;
                    end
                    default:
                    begin
                        state_next = fba_pkg::S_RESP;
                    end
                endcase
            end
            fba_pkg::S_SCAN:
            begin
                priority if (stat.grp_hit)
                begin
                    cmd.idx_from_scan = 1'b1;
                    state_next        = fba_pkg::S_READ;
                end
                else if (stat.grp_last)
                begin
                    cmd.set_nofree = 1'b1;
                    state_next     = fba_pkg::S_RESP;
                end
                else
                begin
                    cmd.grp_inc = 1'b1;
                end
            end
            fba_pkg::S_READ:
            begin
                // wait out the registered RAM read
                state_next = fba_pkg::S_MODIFY;
            end
            fba_pkg::S_MODIFY:
            begin
                cmd.mem_write = 1'b1;
                state_next    = fba_pkg::S_RESP;
            end
            fba_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/fba_datapath.sv
`timescale 1ns / 1ps
module fba_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fba_pkg::OP_W-1:0]          s_tuser,
    input  logic [fba_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fba_pkg::STATUS_W-1:0]      m_tuser,
    output logic [fba_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  fba_pkg::fba_cmd_t                 cmd,
    output fba_pkg::fba_stat_t                stat
);

    // item fields
    fba_pkg::op_t                      op_reg;
    logic [fba_pkg::BIT_IDX_W-1:0]     bit_sel_reg;
    logic                              present_reg;
    logic                              user_reg;
    logic                              wr_reg;

    logic [fba_pkg::WORD_IDX_W-1:0]    idx_reg;
    logic [fba_pkg::GROUP_IDX_W-1:0]   grp_reg;

    // per-word flags: row written since reset, and row has no free bit
    logic [fba_pkg::WORD_COUNT-1:0]    row_valid_reg;
    logic [fba_pkg::WORD_COUNT-1:0]    row_full_reg;

    fba_pkg::status_t                  res_status_reg;
    logic [fba_pkg::FRAME_W-1:0]       res_frame_reg;
    logic [fba_pkg::ENTRY_W-1:0]       res_entry_reg;

    logic                              out_valid_reg;
    logic [fba_pkg::STATUS_W-1:0]      out_user_reg;
    logic [fba_pkg::OUT_DATA_W-1:0]    out_data_reg;

    logic [fba_pkg::GROUP_SIZE-1:0]    grp_full;
    logic [fba_pkg::GROUP_SEL_W-1:0]   grp_sel;
    logic [fba_pkg::WORD_BITS-1:0]     ram_rdata;
    logic [fba_pkg::WORD_BITS-1:0]     word_cur;
    logic [fba_pkg::WORD_BITS-1:0]     word_new;
    logic [fba_pkg::BIT_IDX_W-1:0]     zero_bit;
    logic [fba_pkg::BIT_IDX_W-1:0]     tgt_bit;
    logic [fba_pkg::FRAME_W-1:0]       found_frame;
    logic                              is_alloc;

    fba_ram #(
        .WIDTH (fba_pkg::WORD_BITS),
        .DEPTH (fba_pkg::WORD_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (cmd.mem_write),
        .waddr (idx_reg),
        .wdata (word_new),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign grp_full = row_full_reg[grp_reg * fba_pkg::GROUP_SIZE +: fba_pkg::GROUP_SIZE];

    always_comb
    begin
        grp_sel = '0;
        for (int i = fba_pkg::GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (!grp_full[i])
            begin
                grp_sel = fba_pkg::GROUP_SEL_W'(i);
            end
        end
    end

    // rows never written read as all free
    assign word_cur = row_valid_reg[idx_reg] ? ram_rdata : '0;

    always_comb
    begin
        zero_bit = '0;
        for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_cur[i])
            begin
                zero_bit = fba_pkg::BIT_IDX_W'(i);
            end
        end
    end

    assign is_alloc    = (op_reg == fba_pkg::OP_ALLOC);
    assign tgt_bit     = is_alloc ? zero_bit : bit_sel_reg;
    assign found_frame = {idx_reg, zero_bit};

    always_comb
    begin
        word_new          = word_cur;
        word_new[tgt_bit] = (op_reg != fba_pkg::OP_FREE);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            op_reg      <= fba_pkg::op_t'(s_tuser);
            bit_sel_reg <= s_tdata[fba_pkg::BIT_IDX_W-1:0];
            present_reg <= s_tdata[12];
            user_reg    <= s_tdata[44];
            wr_reg      <= s_tdata[45];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            idx_reg <= s_tdata[fba_pkg::BIT_IDX_W +: fba_pkg::WORD_IDX_W];
            grp_reg <= '0;
        end
        else if (cmd.idx_from_scan)
        begin
            idx_reg <= {grp_reg, grp_sel};
        end
        else if (cmd.grp_inc)
        begin
            grp_reg <= grp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end
        else if (cmd.mem_write)
        begin
            row_valid_reg[idx_reg] <= 1'b1;
            row_full_reg[idx_reg]  <= &word_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            res_status_reg <= fba_pkg::STAT_OK;
            res_frame_reg  <= '0;
            res_entry_reg  <= s_tdata[43:12];
        end
        else if (cmd.set_present)
        begin
            res_status_reg <= fba_pkg::STAT_PRESENT;
        end
        else if (cmd.set_nofree)
        begin
            res_status_reg <= fba_pkg::STAT_NOFREE;
        end
        else if (cmd.mem_write && is_alloc)
        begin
            res_frame_reg <= found_frame;
            res_entry_reg <= {{(fba_pkg::ENTRY_W - fba_pkg::FRAME_W - fba_pkg::PAGE_SHIFT){1'b0}},
                              found_frame, {(fba_pkg::PAGE_SHIFT - 3){1'b0}},
                              user_reg, wr_reg, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_user_reg <= res_status_reg;
            out_data_reg <= {4'b0000, res_entry_reg, res_frame_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

    assign stat.op       = op_reg;
    assign stat.present  = present_reg;
    assign stat.grp_hit  = ~&grp_full;
    assign stat.grp_last = (grp_reg == fba_pkg::GROUP_IDX_W'(fba_pkg::GROUP_COUNT - 1));
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule
